@@ rtl/core/rgb565_rainbow_cycler_assert.svh @@
// Assertion macros used by the rainbow cycler RTL.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef RGB565_RAINBOW_CYCLER_ASSERT_SVH
`define RGB565_RAINBOW_CYCLER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is high.
`define RRC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RRC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/rrc_pkg.sv @@
// Types and constants for the RGB565 rainbow cycler.
// Used by rrc_wheel_step, rgb565_rainbow_cycler and the testbench; depends on nothing.
package rrc_pkg;

   // Channel limits and reset levels.
   localparam logic [5:0] GREEN_MAX = 6'd63;
   localparam logic [4:0] RB_MAX    = 5'd31;
   localparam logic [4:0] STEP_RESET = 5'd1;

   // Operation codes of an input item.
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_LOAD    = 1'b1;

   // Position on the color wheel.
   typedef enum logic [2:0] {
      PHASE_GREEN_UP   = 3'd0,
      PHASE_RED_DOWN   = 3'd1,
      PHASE_BLUE_UP    = 3'd2,
      PHASE_GREEN_DOWN = 3'd3,
      PHASE_RED_UP     = 3'd4,
      PHASE_BLUE_DOWN  = 3'd5
   } phase_type;

   // Channel levels plus the current phase.
   typedef struct packed {
      logic [4:0] red;
      logic [5:0] green;
      logic [4:0] blue;
      phase_type  phase;
   } wheel_state_type;

   localparam wheel_state_type WHEEL_RESET = '{
      red:   RB_MAX,
      green: 6'd0,
      blue:  5'd0,
      phase: PHASE_GREEN_UP
   };

endpackage

@@ rtl/core/rrc_wheel_step.sv @@
// Combinational advance of the color wheel by one step.
// Depends on rrc_pkg for the state struct, phase codes and limits.
module rrc_wheel_step
   import rrc_pkg::*;
(
   input  wheel_state_type cur_state,
   input  logic [4:0]      amount,
   output wheel_state_type nxt_state,
   output logic [15:0]     nxt_word
);

   // Candidate levels for every channel, rising and falling.
   logic [6:0] green_sum;
   logic [5:0] red_sum;
   logic [5:0] blue_sum;
   logic [5:0] twice_amount;
   logic       green_low;
   logic       red_low;
   logic       blue_low;

   always_comb begin
      green_sum    = {1'b0, cur_state.green} + {2'b00, amount};
      red_sum      = {1'b0, cur_state.red} + {1'b0, amount};
      blue_sum     = {1'b0, cur_state.blue} + {1'b0, amount};
      twice_amount = {amount, 1'b0};
      // A falling channel that cannot lose two steps ends at zero.
      green_low    = cur_state.green < twice_amount;
      red_low      = {1'b0, cur_state.red} < twice_amount;
      blue_low     = {1'b0, cur_state.blue} < twice_amount;
   end

   // Move the active channel and step the phase when it reaches its end.
   always_comb begin
      nxt_state = cur_state;
      case (cur_state.phase)
         PHASE_GREEN_UP: begin
            if (green_sum >= {1'b0, GREEN_MAX}) begin
               nxt_state.green = GREEN_MAX;
               nxt_state.phase = PHASE_RED_DOWN;
            end else begin
               nxt_state.green = green_sum[5:0];
            end
         end
         PHASE_RED_DOWN: begin
            if (red_low) begin
               nxt_state.red   = 5'd0;
               nxt_state.phase = PHASE_BLUE_UP;
            end else begin
               nxt_state.red = cur_state.red - amount;
            end
         end
         PHASE_BLUE_UP: begin
            if (blue_sum >= {1'b0, RB_MAX}) begin
               nxt_state.blue  = RB_MAX;
               nxt_state.phase = PHASE_GREEN_DOWN;
            end else begin
               nxt_state.blue = blue_sum[4:0];
            end
         end
         PHASE_GREEN_DOWN: begin
            if (green_low) begin
               nxt_state.green = 6'd0;
               nxt_state.phase = PHASE_RED_UP;
            end else begin
               nxt_state.green = cur_state.green - {1'b0, amount};
            end
         end
         PHASE_RED_UP: begin
            if (red_sum >= {1'b0, RB_MAX}) begin
               nxt_state.red   = RB_MAX;
               nxt_state.phase = PHASE_BLUE_DOWN;
            end else begin
               nxt_state.red = red_sum[4:0];
            end
         end
         PHASE_BLUE_DOWN: begin
            if (blue_low) begin
               nxt_state.blue  = 5'd0;
               nxt_state.phase = PHASE_GREEN_UP;
            end else begin
               nxt_state.blue = cur_state.blue - amount;
            end
         end
         default: begin
            // Unused phase codes leave the wheel where it is.
            nxt_state = cur_state;
         end
      endcase
   end

   // Rebuild the packed word from the new levels.
   assign nxt_word = {nxt_state.red, nxt_state.green, nxt_state.blue};

endmodule

@@ rtl/core/rgb565_rainbow_cycler.sv @@
// RGB565 rainbow cycler: input register, one-step wheel logic, result register.
// An accepted item passes through the input register and then the result register.
// Throughput is one item per cycle while the receiver does not stall; the result register is the only stall point.
// Synchronous active-high reset empties both stages and restores the step and levels.
// Depends on rrc_pkg, rrc_wheel_step and rgb565_rainbow_cycler_assert.svh.
`include "rgb565_rainbow_cycler_assert.svh"

module rgb565_rainbow_cycler
   import rrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration write
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_color,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_rgb565
);

   logic [4:0]      step_ff;
   logic [4:0]      amount;
   logic            in_valid_ff;
   logic            in_operation_ff;
   logic [15:0]     in_color_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic [15:0]     color_word_ff;
   logic [15:0]     color_word_in;
   wheel_state_type state_ff;
   wheel_state_type state_in;
   wheel_state_type step_state;
   logic [15:0]     step_word;
   logic            advance;

   // Step register; a zero step behaves as a step of one.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_write_enable) begin
         step_ff <= csr_write_data;
      end
   end

   assign amount = (step_ff == 5'd0) ? 5'd1 : step_ff;

   // The held item moves on when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_operation_ff <= req_operation;
         in_color_ff     <= req_color;
      end
   end

   rrc_wheel_step u_wheel_step (
      .cur_state (state_ff),
      .amount    (amount),
      .nxt_state (step_state),
      .nxt_word  (step_word)
   );

   // Next wheel state, packed word and result valid.
   always_comb begin
      state_in      = state_ff;
      color_word_in = color_word_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = 1'b1;
         if (in_operation_ff == OP_LOAD) begin
            color_word_in = in_color_ff;
         end else begin
            state_in      = step_state;
            color_word_in = step_word;
         end
      end
   end

   // Wheel state and the packed word, which is also the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= WHEEL_RESET;
         color_word_ff <= 16'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         color_word_ff <= color_word_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_rgb565 = color_word_ff;

   // An advance shows the packed levels in the result.
   `RRC_ASSERT_NEXT(a_advance_packs_levels, clock, reset,
      advance && (in_operation_ff == OP_ADVANCE),
      rsp_rgb565 == {state_ff.red, state_ff.green, state_ff.blue},
      "advance result does not match channel levels")

   // A load shows the loaded word and leaves the levels alone.
   `RRC_ASSERT_NEXT(a_load_word, clock, reset,
      advance && (in_operation_ff == OP_LOAD),
      (rsp_rgb565 == $past(in_color_ff)) && (state_ff == $past(state_ff)),
      "load result wrong or levels disturbed")

   // Green sits at its maximum while red falls and blue rises.
   `RRC_ASSERT_IMPL(a_green_full, clock, reset,
      (state_ff.phase == PHASE_RED_DOWN) || (state_ff.phase == PHASE_BLUE_UP),
      state_ff.green == GREEN_MAX,
      "green not at maximum in red-down or blue-up phase")

   // Red is empty while blue rises and green falls.
   `RRC_ASSERT_IMPL(a_red_empty, clock, reset,
      (state_ff.phase == PHASE_BLUE_UP) || (state_ff.phase == PHASE_GREEN_DOWN),
      state_ff.red == 5'd0,
      "red not empty in blue-up or green-down phase")

endmodule

@@ bench/tb_rgb565_rainbow_cycler.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgb565_rainbow_cycler: a scoreboard class predicts each packed
// color word from the accepted transfers, and plain tasks drive the block. Depends on rrc_pkg.

module tb_rgb565_rainbow_cycler
   import rrc_pkg::*;
();

   // Tracks the color wheel as the block should and holds the words it must return.
   class rainbow_scoreboard;
      logic [4:0]  step_value;
      logic [4:0]  red;
      logic [5:0]  green;
      logic [4:0]  blue;
      phase_type   phase;
      logic [15:0] word;
      logic [15:0] expected_words[$];
      int errors;
      int checked;
      int advances;
      int loads;
      int wheel_trips;

      function new();
         step_value = STEP_RESET;
         red = RB_MAX;
         green = '0;
         blue = '0;
         phase = PHASE_GREEN_UP;
         word = '0;
      endfunction

      function void set_step(logic [4:0] value);
         step_value = value;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // A rising channel stops at its maximum.
      function int raise_level(int level, int amount, int top, output bit done);
         int sum;
         sum = level + amount;
         done = (sum >= top);
         return done ? top : sum;
      endfunction

      // A falling channel goes to zero once it cannot take another full step.
      function int lower_level(int level, int amount, output bit done);
         if (level < amount || level - amount < amount) begin
            done = 1'b1;
            return 0;
         end
         done = 1'b0;
         return level - amount;
      endfunction

      // Called for every accepted input transfer.
      function void note_transfer(logic operation, logic [15:0] color);
         int amount;
         bit done;
         amount = (step_value == 0) ? 1 : int'(step_value);
         done = 1'b0;
         if (operation == OP_LOAD) begin
            // A load replaces the word only; levels and phase stay.
            word = color;
            loads++;
         end else begin
            advances++;
            case (phase)
               PHASE_GREEN_UP:   green = 6'(raise_level(green, amount, GREEN_MAX, done));
               PHASE_RED_DOWN:   red = 5'(lower_level(red, amount, done));
               PHASE_BLUE_UP:    blue = 5'(raise_level(blue, amount, RB_MAX, done));
               PHASE_GREEN_DOWN: green = 6'(lower_level(green, amount, done));
               PHASE_RED_UP:     red = 5'(raise_level(red, amount, RB_MAX, done));
               default:          blue = 5'(lower_level(blue, amount, done));
            endcase
            if (done) begin
               if (phase == PHASE_BLUE_DOWN) begin
                  phase = PHASE_GREEN_UP;
                  wheel_trips++;
               end else begin
                  phase = phase_type'(phase + 3'd1);
               end
            end
            word = {red, green, blue};
         end
         expected_words.push_back(word);
      endfunction

      // Called for every accepted result transfer.
      function void check_result(logic [15:0] actual);
         logic [15:0] expected;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result rgb565=%h with nothing outstanding",
                     $time, actual);
            errors++;
            return;
         end
         expected = expected_words.pop_front();
         checked++;
         if (actual !== expected) begin
            $display("%0t: rgb565 mismatch, expected %h, actual %h", $time, expected, actual);
            errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [4:0]  csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [15:0] req_color;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_rgb565;

   rainbow_scoreboard wheel_sb;
   int cycle_count;
   int hold_requests;
   int holds_served;
   int hold_left;
   int stall_left;
   stall_mode_type stall_mode;
   int step_settings;

   rgb565_rainbow_cycler dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rgb565       (rsp_rgb565)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Run limit.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result monitor: every result transfer is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         wheel_sb.check_result(rsp_rgb565);
   end

   // Receiver stall pattern, with a long hold-off whenever one is requested.
   initial begin
      rsp_stall = 1'b0;
      holds_served = 0;
      hold_left = 0;
      stall_left = 0;
      stall_mode = STALL_NONE;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            if (stall_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               stall_left = $urandom_range(16, 80);
            end
            stall_left--;
            case (stall_mode)
               STALL_NONE:  rsp_stall = 1'b0;
               STALL_LIGHT: rsp_stall = ($urandom_range(0, 9) < 3);
               STALL_HEAVY: rsp_stall = ($urandom_range(0, 9) < 7);
               default:     rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   // Offer one item and wait for its transfer.
   task automatic send_item(logic operation, logic [15:0] color);
      @(negedge clock);
      req_valid = 1'b1;
      req_operation = operation;
      req_color = color;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      wheel_sb.note_transfer(operation, color);
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (wheel_sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the step register while the block is idle.
   task automatic program_step(logic [4:0] value);
      wait_idle();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(posedge clock);
      wheel_sb.set_step(value);
      step_settings++;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send_advances(int count);
      repeat (count) send_item(OP_ADVANCE, 16'($urandom));
   endtask

   // Random items in bursts with gaps; a hold-off starts with a gap-free burst.
   task automatic run_items(int count, bit with_hold);
      int burst_left;
      int gap;
      burst_left = 0;
      if (with_hold) begin
         hold_requests++;
         burst_left = 24;
      end
      repeat (count) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               @(negedge clock);
               req_valid = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
         if ($urandom_range(0, 99) < 12)
            send_item(OP_LOAD, 16'($urandom));
         else
            send_item(OP_ADVANCE, 16'($urandom));
      end
   endtask

   // Main sequence.
   initial begin
      int drain_cycles;
      wheel_sb = new();
      hold_requests = 0;
      step_settings = 1;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_operation = OP_ADVANCE;
      req_color = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset step: two advances, loads of the extreme and alternating words, which keep the levels, then one advance.
      send_advances(2);
      send_item(OP_LOAD, 16'h0000);
      send_item(OP_LOAD, 16'hFFFF);
      send_item(OP_LOAD, 16'hAAAA);
      send_item(OP_LOAD, 16'h5555);
      send_advances(1);

      // Largest step: green clamps at its maximum.
      program_step(5'd31);
      send_advances(2);

      // Small step takes red part way down.
      program_step(5'd2);
      send_advances(2);

      // A step larger than red clears it, then the rest of the wheel back to the start.
      program_step(5'd30);
      send_advances(9);

      // A zero step moves by one.
      program_step(5'd0);
      send_advances(3);
      send_item(OP_LOAD, 16'hF81F);

      // Random part: a full trip at step one, then several other settings.
      program_step(5'd1);
      run_items(300, 1'b0);
      program_step(5'd31);
      run_items(55, 1'b1);
      program_step(5'($urandom_range(1, 31)));
      run_items(55, 1'b0);
      program_step(5'd0);
      run_items(55, 1'b0);
      program_step(5'($urandom_range(1, 31)));
      run_items(55, 1'b1);
      program_step(5'd16);
      run_items(55, 1'b0);
      program_step(5'($urandom_range(1, 31)));
      run_items(55, 1'b0);
      program_step(5'($urandom_range(1, 31)));
      run_items(55, 1'b0);

      // Drain, with a bound, and let the pipeline settle.
      @(negedge clock);
      req_valid = 1'b0;
      drain_cycles = 0;
      while (wheel_sb.pending() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (wheel_sb.pending() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, wheel_sb.pending());
         wheel_sb.errors++;
      end

      $display("Run covered %0d advances and %0d loads over %0d step settings, %0d wheel trips.",
               wheel_sb.advances, wheel_sb.loads, step_settings, wheel_sb.wheel_trips);
      $display("%0d results compared, %0d errors.", wheel_sb.checked, wheel_sb.errors);
      if (wheel_sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rrc_pkg.sv
rtl/core/rrc_wheel_step.sv
rtl/core/rgb565_rainbow_cycler.sv
bench/tb_rgb565_rainbow_cycler.sv
